### rtl/mer_pkg.sv
// Shared constants and types of the midpoint ellipse rasterizer.
`default_nettype none

package mer_pkg;

  // Field widths
  localparam int COORD_BITS  = 11;
  localparam int RADIUS_BITS = 10;
  localparam int PIX_W       = 13;

  // Offsets carry one spare bit above the radius
  localparam int OFS_W  = RADIUS_BITS + 1;
  // Squared radius
  localparam int SQ_W   = 2 * RADIUS_BITS;
  // Second multiplier operand: holds (2x+1)^2 and (y-1)^2
  localparam int MB_W   = 2 * OFS_W + 2;
  localparam int PROD_W = SQ_W + MB_W;
  localparam int DEC_W  = 48;

  // Command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  // Stream packing
  localparam int CX_LSB      = 0;
  localparam int CY_LSB      = CX_LSB + COORD_BITS;
  localparam int RX_LSB      = CY_LSB + COORD_BITS;
  localparam int RY_LSB      = RX_LSB + RADIUS_BITS;
  localparam int IN_FIELDS_W = RY_LSB + RADIUS_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_USER_W   = 1;

  localparam int PX_LSB       = 0;
  localparam int PY_LSB       = PX_LSB + PIX_W;
  localparam int OUT_FIELDS_W = PY_LSB + PIX_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_USER_W   = 2;
  localparam int USER_DONE    = 0;
  localparam int USER_BAD     = 1;

  // Operation codes on the input stream
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_BAD,
    CMD_STEP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] rx;
    logic [RADIUS_BITS-1:0] ry;
  } cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [OFS_W-1:0]      x;
    logic [OFS_W-1:0]      y;
    logic                  done;
    logic                  bad;
  } point_t;

endpackage

`default_nettype wire

### rtl/midpoint_ellipse_rasterizer_top.sv
// Midpoint ellipse rasterizer: command queue, point sequencer and pixel emitter.
// A step runs two multiplier passes and the hand-off, a start three multiplier passes, the
// initial decision and the hand-off; this sequencer work overlaps the four pixel beats of
// the previous point. The switch into region 2 adds the states S_T1 to S_T5 and S_R2Q.
// Reset is asynchronous, active low: queue empty, sequencer idle, no ellipse in progress.
`default_nettype none

module midpoint_ellipse_rasterizer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // center_x[10:0], center_y[21:11], radius_x[31:22], radius_y[41:32], zero pad
  input  wire logic [mer_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // op[0]: 0 start, 1 step
  input  wire logic [mer_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  // pixel stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // pixel_x[12:0], pixel_y[25:13], zero pad
  output logic [mer_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // ellipse_done[0], bad_radius[1]
  output logic [mer_pkg::OUT_USER_W-1:0]      m_axis_tuser_o,
  // last_of_point
  output logic             m_axis_tlast_o
);
  import mer_pkg::*;

  // front -> back command queue head
  logic   cmd_valid, cmd_ready;
  cmd_t   cmd;
  // back -> emitter point hand-off
  logic   pt_valid, pt_ready;
  point_t pt;

  mer_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Sequencer handles one command at a time; steps while idle are dropped here.
  mer_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .pt_valid_o  (pt_valid),
    .pt_ready_i  (pt_ready),
    .pt_o        (pt)
  );

  // The emitter's point register lets the sequencer work on the next item
  // while pixels of the current point drain.
  mer_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_valid_i  (pt_valid),
    .pt_ready_o  (pt_ready),
    .pt_i        (pt),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // An error transfer carries no pixel and does not close a point.
  a_bad_is_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[USER_BAD]) |->
      (m_axis_tdata_o == '0 && !m_axis_tlast_o && !m_axis_tuser_o[USER_DONE]))
    else $error("error transfer carries pixel data");

  // While pixels are pending, a new point is taken only as the final beat leaves.
  a_handoff_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_ready && m_axis_tvalid_o) |->
      (m_axis_tready_i && (m_axis_tlast_o || m_axis_tuser_o[USER_BAD])))
    else $error("point taken before previous point drained");

  // A point offered to the emitter stays put until it is taken.
  a_point_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_valid && !pt_ready) |=> (pt_valid && $stable(pt)))
    else $error("point changed while waiting for the emitter");

endmodule

`default_nettype wire

### rtl/mer_front.sv
// Front end: accepts input transfers, classifies them and queues commands.
`default_nettype none

module mer_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [mer_pkg::IN_DATA_W-1:0] in_data_i,
  input  wire logic [mer_pkg::IN_USER_W-1:0] in_user_i,
  output logic                              cmd_valid_o,
  input  wire logic                         cmd_ready_i,
  output mer_pkg::cmd_t                     cmd_o
);
  import mer_pkg::*;

  cmd_t            entry_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   count_q;
  cmd_t            new_cmd;
  logic            push, pop;

  always_comb begin
    new_cmd.cx = in_data_i[CY_LSB-1:CX_LSB];
    new_cmd.cy = in_data_i[RX_LSB-1:CY_LSB];
    new_cmd.rx = in_data_i[RY_LSB-1:RX_LSB];
    new_cmd.ry = in_data_i[IN_FIELDS_W-1:RY_LSB];
    if (in_user_i[0] == OP_STEP) begin
      new_cmd.kind = CMD_STEP;
    end else if (new_cmd.rx == '0 || new_cmd.ry == '0) begin
      new_cmd.kind = CMD_BAD;
    end else begin
      new_cmd.kind = CMD_START;
    end
  end

  assign in_ready_o  = (count_q != (Q_AW + 1)'(Q_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/mer_back.sv
// Point sequencer: midpoint decision updates on one shared multiplier.
`default_nettype none

module mer_back (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  output logic       cmd_ready_o,
  input  mer_pkg::cmd_t cmd_i,
  output logic       pt_valid_o,
  input  wire logic  pt_ready_i,
  output mer_pkg::point_t pt_o
);
  import mer_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQI, S_INIT,
    S_P1, S_P2, S_DEC,
    S_T1, S_T2, S_T3, S_T4, S_T5, S_R2Q,
    S_ADV, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2
  } phase_e;

  state_e                   state_q;
  phase_e                   phase_q;
  logic                     bad_q;
  logic [COORD_BITS-1:0]    cx_q, cy_q;
  logic [RADIUS_BITS-1:0]   rx_q;
  logic [OFS_W-1:0]         x_q, y_q;
  logic [SQ_W-1:0]          rx2_q, ry2_q;
  logic [PROD_W-1:0]        p1_q, p2_q;
  logic signed [DEC_W-1:0]  dec_q, acc_q;

  // shared multiplier, product registered every cycle
  logic [SQ_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod_q;

  logic [OFS_W:0]          tx;
  logic [OFS_W-1:0]        ym;
  logic [PROD_W-1:0]       p2_now;
  logic signed [DEC_W-1:0] rx2s, ry2s, prods, a1, b1, q, q_adj;
  logic signed [DEC_W-1:0] r1_dec, r2_dec;
  logic                    in_r1, r2_move_x;

  assign tx = {x_q, 1'b1};
  assign ym = y_q - 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQX: begin
        mul_a = SQ_W'(rx_q);
        mul_b = MB_W'(rx_q);
      end
      S_SQY: begin
        mul_a = SQ_W'(y_q);
        mul_b = MB_W'(y_q);
      end
      S_SQI: begin
        mul_a = rx2_q;
        mul_b = MB_W'(y_q);
      end
      S_P1: begin
        mul_a = ry2_q;
        mul_b = MB_W'(x_q);
      end
      S_P2: begin
        mul_a = rx2_q;
        mul_b = MB_W'(y_q);
      end
      S_T1: begin
        mul_a = SQ_W'(tx);
        mul_b = MB_W'(tx);
      end
      S_T2: begin
        mul_a = ry2_q;
        mul_b = prod_q[MB_W-1:0];
      end
      S_T3: begin
        mul_a = SQ_W'(ym);
        mul_b = MB_W'(ym);
      end
      S_T4: begin
        mul_a = rx2_q;
        mul_b = prod_q[MB_W-1:0];
      end
      S_T5: begin
        mul_a = rx2_q;
        mul_b = MB_W'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Decision arithmetic. a1 = 2*ry2*(x+1), b1 = 2*rx2*(y-1).
  always_comb begin
    p2_now = (state_q == S_DEC) ? prod_q : p2_q;
    rx2s   = $signed(DEC_W'(rx2_q));
    ry2s   = $signed(DEC_W'(ry2_q));
    prods  = $signed(DEC_W'(prod_q));
    a1     = ($signed(DEC_W'(p1_q)) + ry2s) <<< 1;
    b1     = ($signed(DEC_W'(p2_now)) - rx2s) <<< 1;
    in_r1  = (phase_q == PH_R1) && (p1_q < prod_q);
    if (dec_q[DEC_W-1]) begin
      r1_dec = dec_q + a1 + ry2s;
    end else begin
      r1_dec = dec_q + a1 - b1 + ry2s;
    end
    r2_move_x = !(!dec_q[DEC_W-1] && dec_q != '0);
    if (r2_move_x) begin
      r2_dec = dec_q + a1 - b1 + rx2s;
    end else begin
      r2_dec = dec_q - b1 + rx2s;
    end
    // quarter units, truncated toward zero
    q     = acc_q - (prods <<< 2);
    q_adj = q[DEC_W-1] ? q + DEC_W'(3) : q;
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign pt_valid_o  = (state_q == S_OUT);

  always_comb begin
    pt_o.cx   = cx_q;
    pt_o.cy   = cy_q;
    pt_o.x    = x_q;
    pt_o.y    = y_q;
    pt_o.bad  = bad_q;
    pt_o.done = !bad_q && (y_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_IDLE;
      bad_q   <= 1'b0;
      cx_q    <= '0;
      cy_q    <= '0;
      rx_q    <= '0;
      x_q     <= '0;
      y_q     <= '0;
      rx2_q   <= '0;
      ry2_q   <= '0;
      p1_q    <= '0;
      p2_q    <= '0;
      dec_q   <= '0;
      acc_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.kind)
              CMD_BAD: begin
                bad_q   <= 1'b1;
                phase_q <= PH_IDLE;
                state_q <= S_OUT;
              end
              CMD_START: begin
                bad_q   <= 1'b0;
                cx_q    <= cmd_i.cx;
                cy_q    <= cmd_i.cy;
                rx_q    <= cmd_i.rx;
                x_q     <= '0;
                y_q     <= OFS_W'(cmd_i.ry);
                state_q <= S_SQX;
              end
              CMD_STEP: begin
                bad_q <= 1'b0;
                if (phase_q != PH_IDLE) begin
                  state_q <= S_P1;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SQX: state_q <= S_SQY;
        S_SQY: begin
          rx2_q   <= prod_q[SQ_W-1:0];
          state_q <= S_SQI;
        end
        S_SQI: begin
          ry2_q   <= prod_q[SQ_W-1:0];
          state_q <= S_INIT;
        end
        S_INIT: begin
          dec_q   <= ry2s - prods + $signed(DEC_W'(rx2_q >> 2));
          phase_q <= PH_R1;
          state_q <= S_OUT;
        end
        S_P1: state_q <= S_P2;
        S_P2: begin
          p1_q    <= prod_q;
          state_q <= S_DEC;
        end
        S_DEC: begin
          p2_q <= prod_q;
          if (in_r1) begin
            dec_q <= r1_dec;
            x_q   <= x_q + 1'b1;
            if (!dec_q[DEC_W-1]) begin
              y_q <= y_q - 1'b1;
            end
            state_q <= S_OUT;
          end else if (phase_q == PH_R1) begin
            state_q <= S_T1;
          end else begin
            state_q <= S_ADV;
          end
        end
        S_T1: state_q <= S_T2;
        S_T2: state_q <= S_T3;
        S_T3: begin
          acc_q   <= prods;
          state_q <= S_T4;
        end
        S_T4: state_q <= S_T5;
        S_T5: begin
          acc_q   <= acc_q + (prods <<< 2);
          state_q <= S_R2Q;
        end
        S_R2Q: begin
          dec_q   <= q_adj >>> 2;
          phase_q <= PH_R2;
          state_q <= S_ADV;
        end
        S_ADV: begin
          dec_q <= r2_dec;
          y_q   <= y_q - 1'b1;
          if (r2_move_x) begin
            x_q <= x_q + 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (pt_ready_i) begin
            if (!bad_q && y_q == '0) begin
              phase_q <= PH_IDLE;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/mer_emit.sv
// Pixel emitter: turns one point into its four mirrored pixel transfers, or a bad point into one error transfer.
`default_nettype none

module mer_emit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pt_valid_i,
  output logic                               pt_ready_o,
  input  mer_pkg::point_t                    pt_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [mer_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [mer_pkg::OUT_USER_W-1:0]     out_user_o,
  output logic                               out_last_o
);
  import mer_pkg::*;

  localparam logic [1:0] LAST_BEAT = 2'd3;

  point_t          pt_q;
  logic            busy_q;
  logic [1:0]      beat_q;
  logic            last_beat;
  logic [PIX_W-1:0] cx_ext, cy_ext, x_ext, y_ext, px, py;

  assign last_beat   = pt_q.bad || (beat_q == LAST_BEAT);
  assign pt_ready_o  = !busy_q || (out_ready_i && last_beat);
  assign out_valid_o = busy_q;

  // beat order: (+x,+y) (+x,-y) (-x,+y) (-x,-y)
  always_comb begin
    cx_ext = PIX_W'(pt_q.cx);
    cy_ext = PIX_W'(pt_q.cy);
    x_ext  = PIX_W'(pt_q.x);
    y_ext  = PIX_W'(pt_q.y);
    px     = beat_q[1] ? cx_ext - x_ext : cx_ext + x_ext;
    py     = beat_q[0] ? cy_ext - y_ext : cy_ext + y_ext;
    out_data_o = '0;
    out_user_o = '0;
    if (!pt_q.bad) begin
      out_data_o[PY_LSB-1:PX_LSB]       = px;
      out_data_o[OUT_FIELDS_W-1:PY_LSB] = py;
      out_user_o[USER_DONE]             = pt_q.done;
    end
    out_user_o[USER_BAD] = pt_q.bad;
    out_last_o = !pt_q.bad && (beat_q == LAST_BEAT);
  end

  always_ff @(posedge clk_i) begin
    if (pt_valid_i && pt_ready_o) begin
      pt_q <= pt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= '0;
    end else if (pt_valid_i && pt_ready_o) begin
      busy_q <= 1'b1;
      beat_q <= '0;
    end else if (busy_q && out_ready_i) begin
      if (last_beat) begin
        busy_q <= 1'b0;
      end else begin
        beat_q <= beat_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
